### hdl/bst_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the bitmap slot table: operation codes,
// field widths and the control structs between the table parts.
// -----------------------------------------------------------------------------
package bst_pkg;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned REQ_W   = 48;
   localparam int unsigned RSP_W   = 48;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // occupancy update: set or clear one bit
   typedef struct packed {
      logic              wr_en;
      logic              wr_bit;
      logic [SLOT_W-1:0] slot;
   } map_cmd_type;

   // occupancy status for the transaction in the input register
   typedef struct packed {
      logic              free_found;
      logic [SLOT_W-1:0] free_slot;
      logic              hit;
   } map_stat_type;

endpackage

### hdl/bitmap_slot_table.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bitmap_slot_table
// Handle table of SLOTS slots: put claims the lowest free slot and stores a
// word, get reads the word of an occupied slot, remove reads it and frees the slot.
//
//   channel   direction   payload (low bit first)
//   req_*     in          operation[1:0] slot[9:2] value[41:10]
//   rsp_*     out         ok[0] given_slot[8:1] word_out[40:9]
//
// One transaction per cycle sustained while results are taken; each request
// passes the input register, then the result register and word RAM read.
// Bitmap update and RAM access happen in the cycle the transaction leaves the
// input register, so the next transaction always sees them.
// Reset clears the bitmap and both valid flags; the word RAM is not cleared.
// A stalled result holds the result register; the input register stalls behind it.
// -----------------------------------------------------------------------------
module bitmap_slot_table #(
   parameter int unsigned SLOTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // operation[1:0], slot[9:2], value[41:10], zero fill
   input  logic [bst_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // ok[0], given_slot[8:1], word_out[40:9], zero fill
   output logic [bst_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic                         in_valid_ff;
   bst_pkg::op_type              in_op_ff;
   logic [bst_pkg::SLOT_W-1:0]   in_slot_ff;
   logic [bst_pkg::WORD_W-1:0]   in_value_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_ok_ff;
   logic [bst_pkg::SLOT_W-1:0]   rsp_given_ff;
   logic                         rsp_word_sel_ff;

   logic                         rsp_ok_in;
   logic [bst_pkg::SLOT_W-1:0]   rsp_given_in;
   logic                         rsp_word_sel_in;

   logic                         advance;
   logic                         fire;
   logic                         is_put;
   logic                         is_read;
   logic                         put_ok;
   logic                         read_ok;
   logic [bst_pkg::WORD_W-1:0]   rd_word;

   bst_pkg::map_cmd_type         map_cmd;
   bst_pkg::map_stat_type        map_stat;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= bst_pkg::op_type'(req_tdata[1:0]);
         in_slot_ff  <= req_tdata[9:2];
         in_value_ff <= req_tdata[41:10];
      end
   end

   assign is_put  = (in_op_ff == bst_pkg::OP_PUT);
   assign is_read = (in_op_ff == bst_pkg::OP_GET) || (in_op_ff == bst_pkg::OP_REMOVE);
   assign put_ok  = is_put && map_stat.free_found;
   assign read_ok = is_read && map_stat.hit;

   always_comb begin
      map_cmd.wr_en  = fire && (put_ok || ((in_op_ff == bst_pkg::OP_REMOVE) && map_stat.hit));
      map_cmd.wr_bit = is_put;
      map_cmd.slot   = is_put ? map_stat.free_slot : in_slot_ff;
   end

   bst_bitmap #(
      .SLOTS(SLOTS)
   ) u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .query_slot (in_slot_ff),
      .cmd        (map_cmd),
      .stat       (map_stat)
   );

   bst_word_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (fire && put_ok),
      .wr_addr (map_stat.free_slot[IDX_W-1:0]),
      .wr_data (in_value_ff),
      .rd_en   (fire),
      .rd_addr (in_slot_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rsp_ok_in       = put_ok || read_ok;
   assign rsp_given_in    = put_ok ? map_stat.free_slot : '0;
   assign rsp_word_sel_in = read_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ok_ff       <= rsp_ok_in;
         rsp_given_ff    <= rsp_given_in;
         rsp_word_sel_ff <= rsp_word_sel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, (rsp_word_sel_ff ? rd_word : {bst_pkg::WORD_W{1'b0}}),
                        rsp_given_ff, rsp_ok_ff};

endmodule

### hdl/bst_bitmap.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bst_bitmap
// Occupancy bitmap with lowest-free-slot priority encoder and lookup of the
// queried slot. Cleared by reset.
// -----------------------------------------------------------------------------
module bst_bitmap #(
   parameter int unsigned SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bst_pkg::SLOT_W-1:0] query_slot,
   input  bst_pkg::map_cmd_type       cmd,
   output bst_pkg::map_stat_type      stat
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0] occ_ff;
   logic [SLOTS-1:0] occ_in;
   logic             in_range;

   assign in_range = ({1'b0, query_slot} < (bst_pkg::SLOT_W + 1)'(SLOTS));

   always_comb begin
      stat.free_found = 1'b0;
      stat.free_slot  = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (!occ_ff[k]) begin
            stat.free_found = 1'b1;
            stat.free_slot  = bst_pkg::SLOT_W'(k);
         end
      end
      stat.hit = in_range && occ_ff[query_slot[IDX_W-1:0]];
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.wr_en) begin
         occ_in[cmd.slot[IDX_W-1:0]] = cmd.wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

### hdl/bst_word_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bst_word_ram
// Slot word store: one write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module bst_word_ram #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [bst_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [bst_pkg::WORD_W-1:0] rd_data
);

   logic [bst_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bst_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_slot_table. A queue-fed driver sends get, put,
// remove and no-op transactions in bursts with random gaps. The monitor keeps
// its own occupancy bitmap and stored words, predicts every answer when the
// request is taken, and checks the results in order while the result side
// stalls on a changing pattern.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned TABLE_SLOTS  = 64;
   localparam int unsigned RANDOM_ITEMS = 1950;

   // highest field first, matching the channel layout
   typedef struct packed {
      logic [bst_pkg::WORD_W-1:0] value;
      logic [bst_pkg::SLOT_W-1:0] slot;
      bst_pkg::op_type            op;
   } table_req_type;

   typedef struct packed {
      logic [bst_pkg::WORD_W-1:0] word_out;
      logic [bst_pkg::SLOT_W-1:0] given_slot;
      logic                       ok;
   } table_rsp_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;
   typedef enum int {READY_ALWAYS, READY_TOGGLE, READY_COIN, READY_RARE} ready_pattern_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [bst_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [bst_pkg::RSP_W-1:0] rsp_tdata;

   table_req_type              pending_reqs[$];
   table_rsp_type              answers_due[$];
   logic                       slot_taken [TABLE_SLOTS];
   logic [bst_pkg::WORD_W-1:0] slot_word  [TABLE_SLOTS];

   int unsigned       errors        = 0;
   int unsigned       checked       = 0;
   int unsigned       puts_placed   = 0;
   int unsigned       puts_refused  = 0;
   int unsigned       lookups_hit   = 0;
   int unsigned       lookups_miss  = 0;
   int unsigned       fill_count    = 0;
   int unsigned       peak_fill     = 0;
   int unsigned       burst_left    = 0;
   int unsigned       gap_left      = 0;
   int unsigned       stall_left    = 0;
   ready_pattern_type stall_kind    = READY_ALWAYS;

   bitmap_slot_table #(
      .SLOTS(TABLE_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic table_rsp_type answer_request(table_req_type r);
      table_rsp_type a;
      int            k;
      a = '0;
      case (r.op)
         bst_pkg::OP_PUT: begin
            for (k = 0; k < TABLE_SLOTS; k++) begin
               if (!a.ok && !slot_taken[k]) begin
                  slot_taken[k] = 1'b1;
                  slot_word[k]  = r.value;
                  a.ok          = 1'b1;
                  a.given_slot  = bst_pkg::SLOT_W'(k);
               end
            end
         end
         bst_pkg::OP_GET, bst_pkg::OP_REMOVE: begin
            if (r.slot < TABLE_SLOTS && slot_taken[r.slot]) begin
               a.ok       = 1'b1;
               a.word_out = slot_word[r.slot];
               if (r.op == bst_pkg::OP_REMOVE) begin
                  slot_taken[r.slot] = 1'b0;
                  slot_word[r.slot]  = '0;
               end
            end
         end
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic table_req_type random_request(op_mix_type mix);
      table_req_type r;
      int unsigned   roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  r.op = (roll < 70) ? bst_pkg::OP_PUT : (roll < 88) ? bst_pkg::OP_GET :
                           (roll < 97) ? bst_pkg::OP_REMOVE : bst_pkg::OP_NONE;
         MIX_DRAIN: r.op = (roll < 15) ? bst_pkg::OP_PUT : (roll < 40) ? bst_pkg::OP_GET :
                           (roll < 97) ? bst_pkg::OP_REMOVE : bst_pkg::OP_NONE;
         default:   r.op = (roll < 34) ? bst_pkg::OP_PUT : (roll < 62) ? bst_pkg::OP_GET :
                           (roll < 94) ? bst_pkg::OP_REMOVE : bst_pkg::OP_NONE;
      endcase
      if ($urandom_range(0, 6) == 0)
         r.slot = bst_pkg::SLOT_W'($urandom_range(TABLE_SLOTS, 255));
      else
         r.slot = bst_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
      roll = $urandom_range(0, 19);
      r.value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
      return r;
   endfunction

   task automatic push_req(bst_pkg::op_type op, int unsigned slot,
                           logic [bst_pkg::WORD_W-1:0] value);
      table_req_type r;
      r.op    = op;
      r.slot  = bst_pkg::SLOT_W'(slot);
      r.value = value;
      pending_reqs.push_back(r);
   endtask

   always @(posedge clock) begin : sender
      table_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            item = pending_reqs.pop_front();
            req_tdata  <= bst_pkg::REQ_W'(item);
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_kind = ready_pattern_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         case (stall_kind)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_TOGGLE: rsp_tready <= ~rsp_tready;
            READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
            default:      rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      table_rsp_type got;
      table_rsp_type want;
      table_req_type seen;
      int            k;
      if (reset) begin
         for (k = 0; k < TABLE_SLOTS; k++) begin
            slot_taken[k] = 1'b0;
            slot_word[k]  = '0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(table_rsp_type)-1:0];
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result ok=%0d given_slot=%0d word_out=%h",
                        $time, got.ok, got.given_slot, got.word_out);
            end else begin
               want = answers_due.pop_front();
               checked++;
               if (got.ok !== want.ok) begin
                  errors++;
                  $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
               end
               if (got.given_slot !== want.given_slot) begin
                  errors++;
                  $display("%0t: given_slot expected %0d actual %0d",
                           $time, want.given_slot, got.given_slot);
               end
               if (got.word_out !== want.word_out) begin
                  errors++;
                  $display("%0t: word_out expected %h actual %h",
                           $time, want.word_out, got.word_out);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen = req_tdata[$bits(table_req_type)-1:0];
            want = answer_request(seen);
            answers_due.push_back(want);
            if (seen.op == bst_pkg::OP_PUT) begin
               if (want.ok) begin
                  puts_placed++;
                  fill_count++;
                  if (fill_count > peak_fill)
                     peak_fill = fill_count;
               end else begin
                  puts_refused++;
               end
            end else if (seen.op == bst_pkg::OP_GET || seen.op == bst_pkg::OP_REMOVE) begin
               if (want.ok) begin
                  lookups_hit++;
                  if (seen.op == bst_pkg::OP_REMOVE)
                     fill_count--;
               end else begin
                  lookups_miss++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      op_mix_type  mix;
      int unsigned block_len;
      int unsigned queued;
      int unsigned waited;

      push_req(bst_pkg::OP_GET,    0,   32'h0000_0000);
      push_req(bst_pkg::OP_REMOVE, 0,   32'hFFFF_FFFF);
      push_req(bst_pkg::OP_NONE,   255, 32'hFFFF_FFFF);
      push_req(bst_pkg::OP_PUT,    255, 32'h0000_0000);
      push_req(bst_pkg::OP_PUT,    0,   32'hFFFF_FFFF);
      push_req(bst_pkg::OP_PUT,    17,  32'h5A5A_A5A5);
      push_req(bst_pkg::OP_GET,    0,   32'hFFFF_FFFF);
      push_req(bst_pkg::OP_GET,    1,   32'h0000_0000);
      push_req(bst_pkg::OP_GET,    TABLE_SLOTS, 32'h0);
      push_req(bst_pkg::OP_GET,    255, 32'h0);
      push_req(bst_pkg::OP_REMOVE, 255, 32'h0);
      push_req(bst_pkg::OP_REMOVE, TABLE_SLOTS, 32'h0);
      push_req(bst_pkg::OP_GET,    TABLE_SLOTS - 1, 32'h0);
      push_req(bst_pkg::OP_REMOVE, 1,   32'h0);
      push_req(bst_pkg::OP_GET,    1,   32'h0);
      push_req(bst_pkg::OP_PUT,    0,   32'h1234_5678);
      push_req(bst_pkg::OP_REMOVE, 0,   32'h0);
      push_req(bst_pkg::OP_REMOVE, 0,   32'h0);
      push_req(bst_pkg::OP_NONE,   0,   32'h0);
      push_req(bst_pkg::OP_PUT,    128, 32'hAAAA_AAAA);
      push_req(bst_pkg::OP_GET,    2,   32'h0);
      push_req(bst_pkg::OP_REMOVE, 2,   32'h0);
      push_req(bst_pkg::OP_GET,    0,   32'h0);

      // overfill from near empty so the full-table refusal is hit early
      repeat (70) push_req(bst_pkg::OP_PUT, $urandom_range(0, 255), $urandom);
      queued = 70;
      while (queued < RANDOM_ITEMS) begin
         mix       = op_mix_type'($urandom_range(0, 2));
         block_len = $urandom_range(40, 160);
         repeat (block_len) pending_reqs.push_back(random_request(mix));
         queued += block_len;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid)
         @(posedge clock);
      waited = 0;
      while (answers_due.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      if (answers_due.size() != 0) begin
         errors++;
         $display("%0t: %0d expected results never arrived", $time, answers_due.size());
      end
      repeat (20) @(posedge clock);

      $display("checked %0d results: %0d puts placed, %0d refused on a full table",
               checked, puts_placed, puts_refused);
      $display("get/remove: %0d hits, %0d misses, peak occupancy %0d of %0d slots",
               lookups_hit, lookups_miss, peak_fill, TABLE_SLOTS);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

### bitmap_slot_table.f
hdl/bst_pkg.sv
hdl/bst_bitmap.sv
hdl/bst_word_ram.sv
hdl/bitmap_slot_table.sv
bench/tb_top.sv
